>>> design/selective_repeat_receiver_top_macros.svh
// Assertion macros shared by the receiver's checking code
`ifndef SELECTIVE_REPEAT_RECEIVER_TOP_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_TOP_MACROS_SVH

// Property must hold at every clock edge outside reset
`define SRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on the following edge
`define SRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/srr_pkg.sv
// Types, widths and codes of the selective-repeat receiver
package srr_pkg;

  localparam int SLOTS    = 32;
  localparam int SEQ_MOD  = 256;
  localparam int SLOT_AW  = $clog2(SLOTS);
  localparam int HELD_W   = $clog2(SLOTS + 1);
  localparam int SEQ_W    = $clog2(SEQ_MOD);
  localparam int SEQ_IN_W = 8;
  localparam int WIN_W    = 5;
  localparam int LEN_W    = 10;
  localparam int HANDLE_W = 10;
  localparam int STAMP_W  = 32;
  localparam int SLOT_DW  = HANDLE_W + LEN_W;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_NACK    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELIVER_IN,
    ST_DRAIN,
    ST_ACK,
    ST_NACK
  } state_e;

  typedef struct packed {
    logic                decode_ok;
    logic                is_data;
    logic                truncated;
    logic [LEN_W-1:0]    payload_length;
    logic [SEQ_IN_W-1:0] seq_in;
    logic [STAMP_W-1:0]  stamp_in;
    logic [HANDLE_W-1:0] buffer_handle;
  } in_t;

  typedef struct packed {
    kind_e               event_kind;
    logic [SEQ_IN_W-1:0] seq_out;
    logic [WIN_W-1:0]    adv_window;
    logic [STAMP_W-1:0]  stamp_out;
    logic [HANDLE_W-1:0] deliver_handle;
    logic [LEN_W-1:0]    deliver_length;
    logic                finished;
    logic                last;
  } result_t;

  typedef struct packed {
    logic [SLOTS-1:0]  slot_valid;
    logic [HELD_W-1:0] held_count;
    logic              done;
  } status_t;

endpackage

>>> design/selective_repeat_receiver_top.sv
// Selective-repeat receiver top level: stream ports, sequencer, slot RAM, output register
//
// Takes one decoded packet header per input beat and emits deliver, ack and nack beats;
// tlast marks the final beat of a header. An ack or nack header gives its ack/nack beat.
// An in-sequence header, unless closing or truncated, gives its own delivery, N drained
// deliveries and the ack, N being the count of successors held in a row: the drain reads
// one slot per cycle while the output register takes beats, from the single read port
// of the slot RAM, prefetching the next slot while the current delivery leaves. Corrupt
// headers, closing headers out of sequence and headers after the transfer has finished
// give nothing. A held result beat in the output register does not stop the next header
// being taken. window_size resets to 31 and may be rewritten while idle.
module selective_repeat_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,     // window_size
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [9:0] payload_length, [17:10] seq_in, [49:18] stamp_in, [59:50] buffer_handle
  input  logic [63:0] s_axis_tdata_i,
  // [0] decode_ok, [1] is_data, [2] truncated
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] seq_out, [12:8] adv_window, [44:13] stamp_out, [54:45] deliver_handle,
  // [64:55] deliver_length
  output logic [71:0] m_axis_tdata_o,
  // [1:0] event_kind, [2] finished
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

`include "selective_repeat_receiver_top_macros.svh"

  srr_pkg::in_t                    in_hdr;
  srr_pkg::result_t                res_seq;
  srr_pkg::result_t                res_out;
  srr_pkg::status_t                status;
  logic                            push;
  logic                            push_ready;
  logic                            mem_we;
  logic [srr_pkg::SLOT_AW-1:0]     mem_waddr;
  logic [srr_pkg::SLOT_DW-1:0]     mem_wdata;
  logic                            mem_re;
  logic [srr_pkg::SLOT_AW-1:0]     mem_raddr;
  logic [srr_pkg::SLOT_DW-1:0]     mem_rdata;

  assign in_hdr.decode_ok      = s_axis_tuser_i[0];
  assign in_hdr.is_data        = s_axis_tuser_i[1];
  assign in_hdr.truncated      = s_axis_tuser_i[2];
  assign in_hdr.payload_length = s_axis_tdata_i[9:0];
  assign in_hdr.seq_in         = s_axis_tdata_i[17:10];
  assign in_hdr.stamp_in       = s_axis_tdata_i[49:18];
  assign in_hdr.buffer_handle  = s_axis_tdata_i[59:50];

  srr_seq_ctrl u_seq_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_i         (in_hdr),
    .push_o       (push),
    .res_o        (res_seq),
    .push_ready_i (push_ready),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .status_o     (status)
  );

  srr_slot_mem #(
    .DEPTH  (srr_pkg::SLOTS),
    .DATA_W (srr_pkg::SLOT_DW)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  srr_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res_seq),
    .ready_o (push_ready),
    .valid_o (m_axis_tvalid_o),
    .res_o   (res_out),
    .take_i  (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {7'b0, res_out.deliver_length, res_out.deliver_handle,
                           res_out.stamp_out, res_out.adv_window, res_out.seq_out};
  assign m_axis_tuser_o = {res_out.finished, res_out.event_kind};
  assign m_axis_tlast_o = res_out.last;

  // held count tracks the number of occupied slots
  `SRR_ASSERT(a_held_matches, status.held_count == srr_pkg::HELD_W'($countones(status.slot_valid)), "held count differs from occupied slots")
  // once the transfer has closed it stays closed
  `SRR_ASSERT_NEXT(a_done_sticky, status.done, status.done, "finished state left")
  // the closing beat is always the final ack of its header
  `SRR_ASSERT(a_finish_is_ack, !(m_axis_tvalid_o && m_axis_tuser_o[2]) || (m_axis_tuser_o[1:0] == srr_pkg::KIND_ACK && m_axis_tlast_o), "finished set on a beat that is not a closing ack")

endmodule

>>> design/srr_slot_mem.sv
// Slot RAM: one write port, one read port, registered read data
module srr_slot_mem #(
  parameter int DEPTH  = 32,
  parameter int DATA_W = 20,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/srr_out_stage.sv
// Output register between the sequencer and the result stream
module srr_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  srr_pkg::result_t res_i,
  output logic            ready_o,
  output logic            valid_o,
  output srr_pkg::result_t res_o,
  input  logic            take_i
);

  logic             valid_q, valid_d;
  srr_pkg::result_t res_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> design/srr_seq_ctrl.sv
// Receive sequencer: window state, slot valid bits and result generation
module srr_seq_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [srr_pkg::WIN_W-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  srr_pkg::in_t                     in_i,
  output logic                             push_o,
  output srr_pkg::result_t                 res_o,
  input  logic                             push_ready_i,
  output logic                             mem_we_o,
  output logic [srr_pkg::SLOT_AW-1:0]      mem_waddr_o,
  output logic [srr_pkg::SLOT_DW-1:0]      mem_wdata_o,
  output logic                             mem_re_o,
  output logic [srr_pkg::SLOT_AW-1:0]      mem_raddr_o,
  input  logic [srr_pkg::SLOT_DW-1:0]      mem_rdata_i,
  output srr_pkg::status_t                 status_o
);

  srr_pkg::state_e state_q, state_d;

  logic [srr_pkg::WIN_W-1:0]    win_q, win_d;
  logic [srr_pkg::SEQ_W-1:0]    expected_q, expected_d;
  logic [srr_pkg::SLOT_AW-1:0]  head_q, head_d;
  logic [srr_pkg::HELD_W-1:0]   held_q, held_d;
  logic                         done_q, done_d;
  logic [srr_pkg::SLOTS-1:0]    slot_valid_q, slot_valid_d;
  logic                         fin_q;

  logic [srr_pkg::STAMP_W-1:0]  stamp_q;
  logic [srr_pkg::SEQ_IN_W-1:0] seq_raw_q;
  logic [srr_pkg::LEN_W-1:0]    len_q;
  logic [srr_pkg::HANDLE_W-1:0] handle_q;

  logic                         take;
  logic                         is_final;
  logic                         in_seq;
  logic [srr_pkg::SEQ_W-1:0]    seq_mod;
  logic [srr_pkg::SEQ_W-1:0]    seq_off;
  logic                         seq_off_ok;
  logic [srr_pkg::SLOT_AW:0]    idx_sum;
  logic [srr_pkg::SLOT_AW:0]    idx_wrap;
  logic [srr_pkg::SLOT_AW-1:0]  store_idx;
  logic                         store_go;
  logic [srr_pkg::SLOT_AW-1:0]  head_inc;
  logic [srr_pkg::SEQ_W-1:0]    expected_inc;
  logic [srr_pkg::WIN_W-1:0]    adv;
  logic                         step;

  // ---- classification of the incoming beat ----
  assign seq_mod    = in_i.seq_in[srr_pkg::SEQ_W-1:0];
  assign take       = in_valid_i && (state_q == srr_pkg::ST_IDLE) && !done_q && in_i.decode_ok;
  assign is_final   = in_i.is_data && (in_i.payload_length == '0) && !in_i.truncated;
  assign in_seq     = (seq_mod == expected_q);
  assign seq_off    = seq_mod - expected_q;
  assign seq_off_ok = (seq_off != '0) && (seq_off < srr_pkg::SEQ_W'(win_q))
                   && (seq_off < srr_pkg::SEQ_W'(srr_pkg::SLOTS));

  // ring position of the packet: head plus offset, modulo the slot count
  assign idx_sum   = {1'b0, head_q} + {1'b0, seq_off[srr_pkg::SLOT_AW-1:0]};
  assign idx_wrap  = idx_sum - (srr_pkg::SLOT_AW + 1)'(srr_pkg::SLOTS);
  assign store_idx = (idx_sum >= (srr_pkg::SLOT_AW + 1)'(srr_pkg::SLOTS))
                   ? idx_wrap[srr_pkg::SLOT_AW-1:0] : idx_sum[srr_pkg::SLOT_AW-1:0];

  assign store_go = take && !is_final && !in_i.truncated && !in_seq && seq_off_ok
                 && (in_i.payload_length != '0) && !slot_valid_q[store_idx];

  assign head_inc     = (head_q == srr_pkg::SLOT_AW'(srr_pkg::SLOTS - 1))
                      ? '0 : head_q + 1'b1;
  assign expected_inc = expected_q + 1'b1;

  assign adv = (held_q >= srr_pkg::HELD_W'(win_q))
             ? '0 : win_q - held_q[srr_pkg::WIN_W-1:0];

  // a delivery beat leaves the sequencer
  assign step = push_ready_i
             && ((state_q == srr_pkg::ST_DELIVER_IN) || (state_q == srr_pkg::ST_DRAIN));

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      srr_pkg::ST_IDLE: begin
        if (take) begin
          if (is_final) begin
            state_d = in_seq ? srr_pkg::ST_ACK : srr_pkg::ST_IDLE;
          end else if (in_seq && !in_i.truncated) begin
            state_d = srr_pkg::ST_DELIVER_IN;
          end else if (in_i.truncated) begin
            state_d = srr_pkg::ST_NACK;
          end else begin
            state_d = srr_pkg::ST_ACK;
          end
        end
      end
      srr_pkg::ST_DELIVER_IN, srr_pkg::ST_DRAIN: begin
        if (push_ready_i) begin
          state_d = slot_valid_q[head_inc] ? srr_pkg::ST_DRAIN : srr_pkg::ST_ACK;
        end
      end
      srr_pkg::ST_ACK, srr_pkg::ST_NACK: begin
        if (push_ready_i) begin
          state_d = srr_pkg::ST_IDLE;
        end
      end
      default: state_d = srr_pkg::ST_IDLE;
    endcase
  end

  // ---- outputs ----
  always_comb begin
    in_ready_o  = (state_q == srr_pkg::ST_IDLE);
    push_o      = 1'b0;
    res_o       = '0;
    mem_we_o    = store_go;
    mem_waddr_o = store_idx;
    mem_wdata_o = {in_i.buffer_handle, in_i.payload_length};
    mem_re_o    = 1'b0;
    mem_raddr_o = head_inc;
    case (state_q)
      srr_pkg::ST_DELIVER_IN: begin
        push_o               = 1'b1;
        res_o.event_kind     = srr_pkg::KIND_DELIVER;
        res_o.seq_out        = srr_pkg::SEQ_IN_W'(expected_q);
        res_o.deliver_handle = handle_q;
        res_o.deliver_length = len_q;
        mem_re_o             = push_ready_i && slot_valid_q[head_inc];
      end
      srr_pkg::ST_DRAIN: begin
        push_o               = 1'b1;
        res_o.event_kind     = srr_pkg::KIND_DELIVER;
        res_o.seq_out        = srr_pkg::SEQ_IN_W'(expected_q);
        res_o.deliver_handle = mem_rdata_i[srr_pkg::SLOT_DW-1:srr_pkg::LEN_W];
        res_o.deliver_length = mem_rdata_i[srr_pkg::LEN_W-1:0];
        mem_re_o             = push_ready_i && slot_valid_q[head_inc];
      end
      srr_pkg::ST_ACK: begin
        push_o           = 1'b1;
        res_o.event_kind = srr_pkg::KIND_ACK;
        res_o.seq_out    = srr_pkg::SEQ_IN_W'(expected_q);
        res_o.adv_window = adv;
        res_o.stamp_out  = stamp_q;
        res_o.finished   = fin_q;
        res_o.last       = 1'b1;
      end
      srr_pkg::ST_NACK: begin
        push_o           = 1'b1;
        res_o.event_kind = srr_pkg::KIND_NACK;
        res_o.seq_out    = seq_raw_q;
        res_o.adv_window = adv;
        res_o.stamp_out  = stamp_q;
        res_o.last       = 1'b1;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  // ---- window state update ----
  always_comb begin
    win_d        = cfg_we_i ? cfg_wdata_i : win_q;
    expected_d   = expected_q;
    head_d       = head_q;
    held_d       = held_q;
    done_d       = done_q;
    slot_valid_d = slot_valid_q;
    if (take && is_final && in_seq) begin
      expected_d = expected_inc;
      head_d     = head_inc;
      done_d     = 1'b1;
    end
    if (store_go) begin
      slot_valid_d[store_idx] = 1'b1;
      held_d                  = held_q + 1'b1;
    end
    if (step) begin
      expected_d = expected_inc;
      head_d     = head_inc;
      if (state_q == srr_pkg::ST_DRAIN) begin
        slot_valid_d[head_q] = 1'b0;
        if (held_q != '0) begin
          held_d = held_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= srr_pkg::ST_IDLE;
      win_q        <= srr_pkg::WIN_W'(31);
      expected_q   <= '0;
      head_q       <= '0;
      held_q       <= '0;
      done_q       <= 1'b0;
      slot_valid_q <= '0;
      fin_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      win_q        <= win_d;
      expected_q   <= expected_d;
      head_q       <= head_d;
      held_q       <= held_d;
      done_q       <= done_d;
      slot_valid_q <= slot_valid_d;
      if (take) begin
        fin_q <= is_final;
      end
    end
  end

  // header fields kept for the result beats
  always_ff @(posedge clk_i) begin
    if (take) begin
      stamp_q   <= in_i.stamp_in;
      seq_raw_q <= in_i.seq_in;
      len_q     <= in_i.payload_length;
      handle_q  <= in_i.buffer_handle;
    end
  end

  assign status_o.slot_valid = slot_valid_q;
  assign status_o.held_count = held_q;
  assign status_o.done       = done_q;

endmodule
